FILE: src/drm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types, constants and tables for the binary64 remainder-by-360 block.
// ----------------------------------------------------------------------------
package drm_pkg;

  localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
  localparam logic [62:0] MAG_360      = 63'h4076_8000_0000_0000;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [10:0] EXP_UNIT     = 11'd1075;
  localparam logic [10:0] EXP_BIAS     = 11'd1023;
  localparam logic [8:0]  MODULUS      = 9'd360;
  localparam logic [7:0]  FOLD_136     = 8'd136;
  localparam logic [11:0] RECIP_12     = 12'd2731;
  localparam logic [11:0] RECIP_360_S  = 12'd2913;
  localparam logic [17:0] RECIP_360_L  = 18'd186413;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        pass;
    logic        kneg;
    logic [5:0]  m;
    logic [63:0] x;
    logic [52:0] low;
  } side_t;

  // 2^(j+3) mod 360, period 12
  function automatic logic [8:0] pow2_mod(input logic [3:0] j);
    logic [8:0] r;
    case (j)
      4'd0:    r = 9'd8;
      4'd1:    r = 9'd16;
      4'd2:    r = 9'd32;
      4'd3:    r = 9'd64;
      4'd4:    r = 9'd128;
      4'd5:    r = 9'd256;
      4'd6:    r = 9'd152;
      4'd7:    r = 9'd304;
      4'd8:    r = 9'd248;
      4'd9:    r = 9'd136;
      4'd10:   r = 9'd272;
      4'd11:   r = 9'd184;
      default: r = 9'd8;
    endcase
    return r;
  endfunction

endpackage

FILE: src/double_remainder_by_360.sv
`timescale 1ns / 1ps
// An eight-stage pipeline carries each input beat to its result beat.
// Throughput: one beat per cycle; every stage advances together when the output
// register is empty or its beat is taken, so a stall holds the whole pipeline.
// Reset: asynchronous, active low; clears all stage valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// double_remainder_by_360
// Binary64 fmod by 360 with the sign of the input; NaN or infinity flags invalid.
// ----------------------------------------------------------------------------
module double_remainder_by_360 import drm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] x_bits_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] result_bits_o,
  output logic        invalid_o
);

  logic       adv;
  logic       mid_valid;
  side_t      mid_side;
  logic [8:0] mid_a;
  logic [8:0] mid_p;

  assign adv     = !valid_o || ready_i;
  assign ready_o = adv;

  drm_reduce u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (valid_i),
    .x_bits_i (x_bits_i),
    .valid_o  (mid_valid),
    .side_o   (mid_side),
    .a_o      (mid_a),
    .p_o      (mid_p)
  );

  drm_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .valid_i       (mid_valid),
    .side_i        (mid_side),
    .a_i           (mid_a),
    .p_i           (mid_p),
    .valid_o       (valid_o),
    .result_bits_o (result_bits_o),
    .invalid_o     (invalid_o)
  );

  a_inv_qnan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && invalid_o |-> result_bits_o == QNAN_BITS)
    else $error("invalid beat without quiet NaN");

  a_ok_finite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !invalid_o |-> result_bits_o[62:52] != EXP_ALL_ONES)
    else $error("valid beat with non-finite result");

  a_ok_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !invalid_o |-> result_bits_o[62:0] < MAG_360)
    else $error("remainder not below 360");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(result_bits_o))
    else $error("stalled result changed");

endmodule

FILE: src/drm_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_reduce
// Decode, residue folding of the significand and power-of-two residue lookup.
// ----------------------------------------------------------------------------
module drm_reduce import drm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  logic [63:0] x_bits_i,
  output logic        valid_o,
  output side_t       side_o,
  output logic [8:0]  a_o,
  output logic [8:0]  p_o
);

  logic [10:0] expo;
  logic [52:0] sig;
  logic [10:0] mdiff;
  logic [10:0] kdiff;
  side_t       side1_d;
  logic [52:0] a1_d;

  logic        v1_q, v2_q, v3_q, v4_q;
  side_t       side1_q, side2_q, side3_q, side4_q;
  logic [52:0] a1_q;
  logic [9:0]  kk1_q;

  always_comb begin
    expo          = x_bits_i[62:52];
    sig           = {1'b1, x_bits_i[51:0]};
    mdiff         = EXP_UNIT - expo;
    kdiff         = expo - EXP_UNIT;
    side1_d.sign  = x_bits_i[63];
    side1_d.nan   = (expo == EXP_ALL_ONES);
    side1_d.pass  = (expo != EXP_ALL_ONES) && (x_bits_i[62:0] < MAG_360);
    side1_d.kneg  = (expo < EXP_UNIT);
    side1_d.m     = side1_d.kneg ? mdiff[5:0] : 6'd0;
    side1_d.x     = x_bits_i;
    side1_d.low   = sig & ~({53{1'b1}} << side1_d.m);
    a1_d          = sig >> side1_d.m;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side1_q <= side1_d;
      a1_q    <= a1_d;
      kk1_q   <= kdiff[9:0];
    end
  end

  logic [13:0] hsum;
  logic [21:0] f2_d;
  logic [9:0]  kv;
  logic [21:0] kprod;
  logic [6:0]  kq;
  logic [9:0]  kr;
  logic [21:0] f2_q;
  logic        ksm2_q;
  logic [1:0]  klo2_q;
  logic [3:0]  r12_2_q;

  always_comb begin
    hsum  = 14'(a1_q[23:12]) + 14'(a1_q[35:24]) + 14'(a1_q[47:36]) + 14'(a1_q[52:48]);
    f2_d  = 22'(a1_q[11:0]) + 22'(hsum * FOLD_136);
    kv    = kk1_q - 10'd3;
    kprod = 22'(kv) * 22'(RECIP_12);
    kq    = kprod[21:15];
    kr    = kv - 10'(kq * 4'd12);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side2_q <= side1_q;
      f2_q    <= f2_d;
      ksm2_q  <= (kk1_q < 10'd3);
      klo2_q  <= kk1_q[1:0];
      r12_2_q <= kr[3:0];
    end
  end

  logic [17:0] g1;
  logic [13:0] g2;
  logic [8:0]  p3_d;
  logic [13:0] g3_q;
  logic [8:0]  p3_q;

  always_comb begin
    g1   = 18'(f2_q[11:0]) + 18'(f2_q[21:12] * FOLD_136);
    g2   = 14'(g1[11:0]) + 14'(g1[17:12] * FOLD_136);
    p3_d = ksm2_q ? (9'd1 << klo2_q) : pow2_mod(r12_2_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side3_q <= side2_q;
      g3_q    <= g2;
      p3_q    <= p3_d;
    end
  end

  logic [12:0] h;
  logic [24:0] hprod;
  logic [4:0]  hq;
  logic [12:0] hr;
  logic [12:0] hr2;
  logic [8:0]  a4_q;
  logic [8:0]  p4_q;

  always_comb begin
    h     = 13'(g3_q[11:0]) + 13'(g3_q[13:12] * FOLD_136);
    hprod = 25'(h) * 25'(RECIP_360_S);
    hq    = hprod[24:20];
    hr    = h - 13'(hq * MODULUS);
    hr2   = (hr >= 13'(MODULUS)) ? hr - 13'(MODULUS) : hr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side4_q <= side3_q;
      a4_q    <= hr2[8:0];
      p4_q    <= p3_q;
    end
  end

  assign valid_o = v4_q;
  assign side_o  = side4_q;
  assign a_o     = a4_q;
  assign p_o     = p4_q;

endmodule

FILE: src/drm_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drm_pack
// Final residue, leading-one search and repacking into binary64.
// ----------------------------------------------------------------------------
module drm_pack import drm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  side_t       side_i,
  input  logic [8:0]  a_i,
  input  logic [8:0]  p_i,
  output logic        valid_o,
  output logic [63:0] result_bits_o,
  output logic        invalid_o
);

  logic        v5_q, v6_q, v7_q, v8_q;
  side_t       side5_q, side6_q, side7_q;
  logic [16:0] prod5_q;
  logic [52:0] remn5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv_i) begin
      v5_q <= valid_i;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side5_q <= side_i;
      prod5_q <= 17'(a_i * p_i);
      remn5_q <= (53'(a_i) << side_i.m) | side_i.low;
    end
  end

  logic [34:0] qprod;
  logic [8:0]  q6;
  logic [16:0] r6;
  logic [16:0] r6c;
  logic [52:0] rem6_q;

  always_comb begin
    qprod = 35'(prod5_q) * 35'(RECIP_360_L);
    q6    = qprod[34:26];
    r6    = prod5_q - 17'(q6 * MODULUS);
    r6c   = (r6 >= 17'(MODULUS)) ? r6 - 17'(MODULUS) : r6;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side6_q <= side5_q;
      rem6_q  <= side5_q.kneg ? remn5_q : 53'(r6c);
    end
  end

  logic [5:0]  top_d;
  logic [5:0]  top7_q;
  logic [52:0] rem7_q;

  always_comb begin
    top_d = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (rem6_q[i]) top_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side7_q <= side6_q;
      rem7_q  <= rem6_q;
      top7_q  <= top_d;
    end
  end

  logic [52:0] norm;
  logic [10:0] biased;
  logic [63:0] res_d;
  logic [63:0] res_q;
  logic        inv_q;

  always_comb begin
    norm   = rem7_q << (6'd52 - top7_q);
    biased = EXP_BIAS + 11'(top7_q) - 11'(side7_q.m);
    if (side7_q.nan) begin
      res_d = QNAN_BITS;
    end else if (side7_q.pass) begin
      res_d = side7_q.x;
    end else if (rem7_q == 53'd0) begin
      res_d = {side7_q.sign, 63'd0};
    end else begin
      res_d = {side7_q.sign, biased, norm[51:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
      inv_q <= side7_q.nan;
    end
  end

  assign valid_o       = v8_q;
  assign result_bits_o = res_q;
  assign invalid_o     = inv_q;

endmodule

FILE: verif/tb_double_remainder_by_360.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_remainder_by_360
// Drives binary64 values into the remainder-by-360 block, predicts fmod(x, 360)
// bit for bit with integer arithmetic, and compares every result beat in order.
// ----------------------------------------------------------------------------
module tb_double_remainder_by_360;
  import drm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [63:0] x_bits_i;
  logic        valid_o;
  logic        ready_i;
  logic [63:0] result_bits_o;
  logic        invalid_o;

  typedef struct packed {
    logic [63:0] bits;
    logic        invalid;
  } fmod_res_t;

  fmod_res_t   fmod_q[$];
  int          mismatch_cnt;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  int          idle_cnt;
  bit          stim_done;

  double_remainder_by_360 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .ready_o       (ready_o),
    .x_bits_i      (x_bits_i),
    .valid_o       (valid_o),
    .ready_i       (ready_i),
    .result_bits_o (result_bits_o),
    .invalid_o     (invalid_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [63:0] pack_pos(logic [63:0] sig, int scale);
    int          top;
    logic [63:0] norm;
    logic [10:0] biased;
    top = 52;
    while (top > 0 && !sig[top]) top--;
    norm   = sig << (52 - top);
    biased = 11'(top + scale + 1023);
    return {1'b0, biased, norm[51:0]};
  endfunction

  function automatic fmod_res_t fmod360(logic [63:0] x);
    fmod_res_t   r;
    logic [10:0] expo;
    logic [63:0] sig;
    logic [63:0] rem;
    logic [63:0] p2;
    int          k;
    int          scale;
    expo = x[62:52];
    r.invalid = 1'b0;
    if (expo == EXP_ALL_ONES) begin
      r.bits = QNAN_BITS;
      r.invalid = 1'b1;
      return r;
    end
    if (x[62:0] < MAG_360) begin
      r.bits = x;
      return r;
    end
    sig = {11'd0, 1'b1, x[51:0]};
    k = int'(expo) - 1075;
    if (k < 0) begin
      rem = sig % (64'd360 << (-k));
      scale = k;
    end else begin
      p2 = 64'd1;
      for (int i = 0; i < k; i++) p2 = (p2 * 2) % 360;
      rem = ((sig % 360) * p2) % 360;
      scale = 0;
    end
    r.bits = (rem == 0) ? {x[63], 63'd0} : ({x[63], 63'd0} | pack_pos(rem, scale));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic send_beat(logic [63:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    x_bits_i <= x;
    fmod_q.push_back(fmod360(x));
    do @(posedge clk_i); while (!ready_o);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (fmod_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_bits();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] x;
    x = rand_bits();
    case ($urandom_range(5))
      0:       x[62:52] = 11'($urandom_range(1031, 1130));
      1:       x[62:52] = 11'($urandom_range(1075, 2046));
      2:       x[62:52] = 11'($urandom_range(1020, 1035));
      3: begin
        x[62:0] = 63'(($urandom_range(1, 100000) * 360));
        x = pack_pos({1'b0, x[62:0]}, 0);
        x[63] = 1'($urandom_range(1));
      end
      default: ;
    endcase
    return x;
  endfunction

  always @(posedge clk_i) begin
    fmod_res_t want;
    if (valid_o && ready_i) begin
      if (fmod_q.size() == 0) begin
        report_mismatch("unexpected beat", result_bits_o, 64'd0);
      end else begin
        want = fmod_q.pop_front();
        if (result_bits_o !== want.bits) report_mismatch("result_bits", result_bits_o, want.bits);
        if (invalid_o !== want.invalid) report_mismatch("invalid", 64'(invalid_o), 64'(want.invalid));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    logic [63:0] pat[$];
    pat = '{64'h0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
            64'h800F_FFFF_FFFF_FFFF, 64'h4076_7FFF_FFFF_FFFF, 64'h4076_8000_0000_0000,
            64'hC076_8000_0000_0000, 64'h4076_8000_0000_0001, 64'h7FF0_0000_0000_0000,
            64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
            64'hFFFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
            64'h4086_8000_0000_0000, 64'h4330_0000_0000_0000, 64'h4340_0000_0000_0001,
            64'hC2F0_0000_0000_0001, 64'h4080_0000_0000_0000, 64'h3FF0_0000_0000_0000,
            64'h7FE0_0000_0000_0000};
    foreach (pat[i]) send_beat(pat[i]);
    drain();
  endtask

  task automatic test_random(int n);
    repeat (n) send_beat(rand_value());
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles <= 200;
    repeat (60) send_beat(rand_value());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    valid_i = 1'b0;
    x_bits_i = 64'd0;
    ready_i = 1'b0;
    mismatch_cnt = 0;
    hold_cycles = 0;
    idle_cnt = 0;
    send_idle_pct = 11;
    recv_idle_pct = 53;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(350);
    send_idle_pct = 53;
    recv_idle_pct = 11;
    test_random(350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(350);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/drm_pkg.sv
src/drm_reduce.sv
src/drm_pack.sv
src/double_remainder_by_360.sv
verif/tb_double_remainder_by_360.sv
